// File: rtl/jms_pkg.sv
package jms_pkg;

    // Widest byte counter supported; also the width used for the offset clamp.
    localparam int unsigned OFFSET_BITS_MAX = 64;
    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned OFFSET_FIELD_BITS = 32;

    // Marker pair bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_STUFF  = 8'h00;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_TEM    = 8'h01;

    // Length field counts itself
    localparam logic [15:0] LEN_SELF = 16'd2;

    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SOI     = 3'd0,
        KIND_EOI     = 3'd1,
        KIND_RST     = 3'd2,
        KIND_TEM     = 3'd3,
        KIND_SEGMENT = 3'd4,
        KIND_LENGTH  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic [7:0]                   code;
        logic [OFFSET_FIELD_BITS-1:0] offset;
        logic [15:0]                  len;
        logic                         bad;
    } result_t;

endpackage

// File: rtl/jpeg_marker_scanner.sv
// JPEG marker scanner. Feed the raw file one byte per word on the s_ side; the
// block walks the byte stream and reports on the m_ side: SOI, EOI, RST0-7 and
// TEM as standalone markers, every other marker code as a segment marker, then
// the big-endian segment length that follows it (bad_length set when it is
// below two), after which length-2 payload bytes are skipped unexamined.
// FF00 is stuffed data and repeated FF fill bytes are ignored. byte_offset is
// the count of bytes taken so far including the reporting one; the internal
// counter is OFFSET_BITS wide, saturates, and is clamped to all ones in the
// 32-bit field. Throughput is one byte per clock while the skid slot is empty:
// the whole phase update and counter step sit between the input handshake and
// the result register, so each result is registered directly from its byte. A
// one-entry skid behind the result register lets one more result-bearing byte
// in while m_tready is low; bytes stall only once both slots hold results.
module jpeg_marker_scanner
    import jms_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] marker_code, [39:8] byte_offset,
                                   // [55:40] segment_length, [56] bad_length
    output logic [2:0]  m_tuser    // [2:0] event_kind
);

    // ---------------------------------------------------------------- state
    phase_t                 phase_reg,   phase_next;
    logic [OFFSET_BITS-1:0] count_reg,   count_next;
    logic [15:0]            skip_reg,    skip_next;
    logic [7:0]             len_hi_reg,  len_hi_next;
    logic [7:0]             marker_reg,  marker_next;

    // result register plus skid slot
    result_t                res_reg,     res_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                skid_reg,    skid_next;
    logic                   skid_valid_reg, skid_valid_next;

    logic                   s_accept;
    logic                   out_free;
    logic                   emit;
    result_t                step_res;
    logic [15:0]            len_full;
    logic [OFFSET_BITS_MAX-1:0] count_wide;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !res_valid_reg || m_tready;

    // Saturating counter, already including the current byte
    assign count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign count_wide = OFFSET_BITS_MAX'(count_next);
    assign len_full   = {len_hi_reg, s_tdata};

    // ---------------------------------------------------- phase decode
    always_comb begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        len_hi_next = len_hi_reg;
        marker_next = marker_reg;
        emit        = 1'b0;

        step_res.kind   = KIND_SEGMENT;
        step_res.code   = s_tdata;
        step_res.len    = '0;
        step_res.bad    = 1'b0;
        // clamp the counter into the 32-bit field
        step_res.offset = (|count_wide[OFFSET_BITS_MAX-1:OFFSET_FIELD_BITS])
                          ? '1 : count_wide[OFFSET_FIELD_BITS-1:0];

        unique case (phase_reg)
            PH_PREFIX: begin
                if (s_tdata != MARK_PREFIX) begin   // fill bytes keep waiting
                    phase_next = PH_SCAN;
                    if (s_tdata == MARK_STUFF) begin
                        emit = 1'b0;                // stuffed data byte
                    end else if (s_tdata == MARK_SOI) begin
                        emit = 1'b1;
                        step_res.kind = KIND_SOI;
                    end else if (s_tdata == MARK_EOI) begin
                        emit = 1'b1;
                        step_res.kind = KIND_EOI;
                    end else if (s_tdata >= MARK_RST0 && s_tdata <= MARK_RST7) begin
                        emit = 1'b1;
                        step_res.kind = KIND_RST;
                    end else if (s_tdata == MARK_TEM) begin
                        emit = 1'b1;
                        step_res.kind = KIND_TEM;
                    end else begin
                        emit = 1'b1;
                        step_res.kind = KIND_SEGMENT;
                        marker_next   = s_tdata;
                        phase_next    = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                len_hi_next = s_tdata;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                emit          = 1'b1;
                step_res.kind = KIND_LENGTH;
                step_res.code = marker_reg;
                step_res.len  = len_full;
                step_res.bad  = (len_full[15:1] == '0);
                if (len_full > LEN_SELF) begin
                    skip_next  = len_full - LEN_SELF;
                    phase_next = PH_SKIP;
                end else begin
                    skip_next  = '0;
                    phase_next = PH_SCAN;
                end
            end
            PH_SKIP: begin
                // payload bytes are not examined
                if (skip_reg != '0) begin
                    skip_next = skip_reg - 1'b1;
                end
                if (skip_reg <= 16'd1) begin
                    phase_next = PH_SCAN;
                end
            end
            default: begin  // scanning, and unused codes behave the same
                phase_next = (s_tdata == MARK_PREFIX) ? PH_PREFIX : PH_SCAN;
            end
        endcase
    end

    // ---------------------------------------------------- output slots
    always_comb begin
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // no byte is taken while the skid is full
                res_next        = skid_reg;
                res_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                res_next       = step_res;
                res_valid_next = s_accept && emit;
            end
        end else if (s_accept && emit) begin
            skid_next       = step_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SCAN;
            count_reg      <= '0;
            skip_reg       <= '0;
            len_hi_reg     <= '0;
            marker_reg     <= '0;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                skip_reg   <= skip_next;
                len_hi_reg <= len_hi_next;
                marker_reg <= marker_next;
            end
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {7'd0, res_reg.bad, res_reg.len, res_reg.offset, res_reg.code};

    // ---------------------------------------------------- assertions
    a_skid_behind_result: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid slot holds a result while the result register is empty");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with nothing left to skip");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !(&count_reg)) |=> (count_reg == OFFSET_BITS'($past(count_reg) + 1'b1)))
        else $error("byte counter did not advance on an accepted byte");

    a_length_from_lo: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && emit && step_res.kind == KIND_LENGTH) |-> (phase_reg == PH_LEN_LO))
        else $error("length reported outside the length low byte phase");

endmodule
